// ----- hw/rtl/rgb_convolution_3x3_mirror_border_macros.svh -----
// Assertion macros for the checker file of the convolution block.
`ifndef RGB_CONVOLUTION_3X3_MIRROR_BORDER_MACROS_SVH
`define RGB_CONVOLUTION_3X3_MIRROR_BORDER_MACROS_SVH

// The condition implies the expression in the same cycle.
`define RGBC_ASSERT_SAME(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("rgbc: same-cycle check failed");

// The condition implies the expression in the following cycle.
`define RGBC_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("rgbc: next-cycle check failed");

`endif

// ----- hw/rtl/rgbc_pkg.sv -----
package rgbc_pkg;

   // Defaults for the top-level parameters.
   localparam int unsigned DEF_MAX_WIDTH      = 1024;
   localparam int unsigned DEF_COEF_FRAC_BITS = 8;

   // Fixed geometry of the kernel and of the fields.
   localparam int unsigned TAPS          = 9;
   localparam int unsigned PIX_BITS      = 24;
   localparam int unsigned ROW_BITS      = 16;
   localparam int unsigned COL_BITS      = 12;
   localparam int unsigned WIDTH_BITS    = 13;
   localparam int unsigned COEF_BITS     = 16;
   localparam int unsigned REQ_DATA_BITS = 24;
   localparam int unsigned RSP_DATA_BITS = 56;
   localparam int unsigned CSR_ADDR_BITS = 6;
   localparam int unsigned CSR_DATA_BITS = 64;

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      REG_COEF_ROW0 = 3'd0,
      REG_COEF_ROW1 = 3'd1,
      REG_COEF_LAST = 3'd2,
      REG_WIDTH     = 3'd3,
      REG_HEIGHT    = 3'd4
   } reg_index_type;

   // Configuration as seen by the datapath.
   typedef struct packed {
      logic [TAPS-1:0][COEF_BITS-1:0] coef;
      logic [10:0]                    image_width;
      logic [15:0]                    image_height;
      logic                           restart;
   } cfg_type;

   // One input pixel after the window shift, with its position and geometry.
   typedef struct packed {
      logic [TAPS-1:0][PIX_BITS-1:0] win;
      logic [ROW_BITS-1:0]           row;
      logic [ROW_BITS-1:0]           height;
      logic [COL_BITS-1:0]           col;
      logic [WIDTH_BITS-1:0]         width;
   } item_type;

endpackage

// ----- hw/rtl/rgbc_csr.sv -----
module rgbc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [rgbc_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [rgbc_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [rgbc_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready,
   output rgbc_pkg::cfg_type                  cfg
);
   import rgbc_pkg::*;

   logic [63:0] row0_ff, row0_in;
   logic [63:0] row1_ff, row1_in;
   logic [15:0] last_ff, last_in;
   logic [10:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic        wr;
   logic [2:0]  idx;
   logic        geom_wr;

   assign csr_pready = 1'b1;
   assign wr         = csr_psel & csr_penable & csr_pwrite;
   assign idx        = csr_paddr[CSR_ADDR_BITS-1:3];

   // Register write decode.
   always_comb begin
      row0_in   = row0_ff;
      row1_in   = row1_ff;
      last_in   = last_ff;
      width_in  = width_ff;
      height_in = height_ff;
      geom_wr   = 1'b0;
      if (wr) begin
         unique case (idx)
            REG_COEF_ROW0: row0_in = csr_pwdata;
            REG_COEF_ROW1: row1_in = csr_pwdata;
            REG_COEF_LAST: last_in = csr_pwdata[15:0];
            REG_WIDTH: begin
               width_in = csr_pwdata[10:0];
               geom_wr  = 1'b1;
            end
            REG_HEIGHT: begin
               height_in = csr_pwdata[15:0];
               geom_wr   = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row0_ff   <= 64'd0;
         row1_ff   <= 64'd256;
         last_ff   <= 16'd0;
         width_ff  <= 11'd640;
         height_ff <= 16'd480;
      end else begin
         row0_ff   <= row0_in;
         row1_ff   <= row1_in;
         last_ff   <= last_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Read-back of the registers.
   always_comb begin
      unique case (idx)
         REG_COEF_ROW0: csr_prdata = row0_ff;
         REG_COEF_ROW1: csr_prdata = row1_ff;
         REG_COEF_LAST: csr_prdata = {48'd0, last_ff};
         REG_WIDTH:     csr_prdata = {53'd0, width_ff};
         REG_HEIGHT:    csr_prdata = {48'd0, height_ff};
         default:       csr_prdata = '0;
      endcase
   end

   // Coefficients in kernel raster order.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         cfg.coef[k]     = row0_ff[16*k +: 16];
         cfg.coef[k + 4] = row1_ff[16*k +: 16];
      end
      cfg.coef[8]      = last_ff;
      cfg.image_width  = width_ff;
      cfg.image_height = height_ff;
      cfg.restart      = geom_wr;
   end

endmodule

// ----- hw/rtl/rgbc_line_buf.sv -----
module rgbc_line_buf #(
   parameter int unsigned MAX_WIDTH = rgbc_pkg::DEF_MAX_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  rgbc_pkg::cfg_type                  cfg,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [rgbc_pkg::REQ_DATA_BITS-1:0] req_tdata,
   output rgbc_pkg::item_type                 item,
   output logic                               item_valid,
   input  logic                               item_take
);
   import rgbc_pkg::*;

   localparam int unsigned AW = $clog2(MAX_WIDTH);

   // Line memory: each entry holds the row above (low half) and two above.
   logic [2*PIX_BITS-1:0] mem [MAX_WIDTH];

   logic [AW-1:0]         col_ff, col_in;
   logic [ROW_BITS-1:0]   row_ff, row_in;
   logic [WIDTH_BITS-1:0] eff_w;
   logic [ROW_BITS-1:0]   eff_h;

   logic                  s1_valid_ff;
   logic [PIX_BITS-1:0]   s1_pix_ff;
   logic [AW-1:0]         s1_col_ff;
   logic [ROW_BITS-1:0]   s1_row_ff;
   logic [WIDTH_BITS-1:0] s1_w_ff;
   logic [ROW_BITS-1:0]   s1_h_ff;
   logic [2*PIX_BITS-1:0] rd_ff;
   logic                  fwd_hit_ff;
   logic [2*PIX_BITS-1:0] fwd_data_ff;

   logic [TAPS-1:0][PIX_BITS-1:0] win_ff, win_in;
   item_type              item_ff;
   logic                  item_valid_ff;

   logic                  accept;
   logic                  s1_adv;
   logic [2*PIX_BITS-1:0] line;
   logic [2*PIX_BITS-1:0] wr_data;
   logic [PIX_BITS-1:0]   col_px [3];

   // Effective geometry.
   always_comb begin
      if (cfg.image_width == 11'd0) begin
         eff_w = WIDTH_BITS'(1);
      end else if (WIDTH_BITS'(cfg.image_width) > WIDTH_BITS'(MAX_WIDTH)) begin
         eff_w = WIDTH_BITS'(MAX_WIDTH);
      end else begin
         eff_w = WIDTH_BITS'(cfg.image_width);
      end
      eff_h = (cfg.image_height == 16'd0) ? 16'd1 : cfg.image_height;
   end

   // Handshake: stage one moves on when the item register is free.
   assign s1_adv     = s1_valid_ff & (~item_valid_ff | item_take);
   assign req_tready = ~s1_valid_ff | s1_adv;
   assign accept     = req_tvalid & req_tready;

   // Raster position of the next pixel.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cfg.restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if ((WIDTH_BITS'(col_ff) + WIDTH_BITS'(1)) >= eff_w) begin
            col_in = '0;
            row_in = ((17'(row_ff) + 17'd1) >= 17'(eff_h)) ? '0 : row_ff + 16'd1;
         end else begin
            col_in = col_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Read data, forwarded from the write of the same edge when both hit one entry.
   assign line      = fwd_hit_ff ? fwd_data_ff : rd_ff;
   assign col_px[0] = line[2*PIX_BITS-1:PIX_BITS];
   assign col_px[1] = line[PIX_BITS-1:0];
   assign col_px[2] = s1_pix_ff;
   assign wr_data   = {col_px[1], s1_pix_ff};

   // Line memory: read on acceptance, write back when stage one moves on.
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= mem[col_ff];
      end
      if (s1_adv) begin
         mem[s1_col_ff] <= wr_data;
      end
   end

   // Stage one payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff   <= req_tdata;
         s1_col_ff   <= col_ff;
         s1_row_ff   <= row_ff;
         s1_w_ff     <= eff_w;
         s1_h_ff     <= eff_h;
         fwd_hit_ff  <= s1_adv && (s1_col_ff == col_ff);
         fwd_data_ff <= wr_data;
      end
   end

   // Window shift: each window row takes the new column on the right.
   always_comb begin
      for (int s = 0; s < 3; s++) begin
         win_in[s*3]     = win_ff[s*3 + 1];
         win_in[s*3 + 1] = win_ff[s*3 + 2];
         win_in[s*3 + 2] = col_px[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (s1_adv) begin
         win_ff <= win_in;
      end
   end

   // Item register towards the result sequencer.
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         item_ff.win    <= win_in;
         item_ff.row    <= s1_row_ff;
         item_ff.height <= s1_h_ff;
         item_ff.col    <= COL_BITS'(s1_col_ff);
         item_ff.width  <= s1_w_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         item_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept | (s1_valid_ff & ~s1_adv);
         if (s1_adv) begin
            item_valid_ff <= 1'b1;
         end else if (item_take) begin
            item_valid_ff <= 1'b0;
         end
      end
   end

   assign item       = item_ff;
   assign item_valid = item_valid_ff;

endmodule

// ----- hw/rtl/rgbc_emit.sv -----
module rgbc_emit #(
   parameter int unsigned COEF_FRAC_BITS = rgbc_pkg::DEF_COEF_FRAC_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  rgbc_pkg::cfg_type                  cfg,
   input  rgbc_pkg::item_type                 item,
   input  logic                               item_valid,
   output logic                               item_take,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [rgbc_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                               rsp_tlast
);
   import rgbc_pkg::*;

   localparam int unsigned POS_BITS  = 18;
   localparam int unsigned PROD_BITS = 25;
   localparam int unsigned SUM_BITS  = 30;

   // Window slot for one kernel offset: clamp to the image, then to the window.
   function automatic logic [1:0] slot_sel(input logic signed [POS_BITS-1:0] o,
                                           input logic [1:0] d,
                                           input logic signed [POS_BITS-1:0] cur,
                                           input logic signed [POS_BITS-1:0] lim);
      logic signed [POS_BITS-1:0] v;
      logic signed [POS_BITS-1:0] s;
      v = o + POS_BITS'(d) - POS_BITS'(1);
      if (v < 0) begin
         v = '0;
      end else if (v > lim) begin
         v = lim;
      end
      s = v - cur + POS_BITS'(2);
      if (s < 0) begin
         return 2'd0;
      end else if (s > 2) begin
         return 2'd2;
      end
      return s[1:0];
   endfunction

   logic pipe_en;

   // Sequencer state.
   item_type cur_ff;
   logic     cur_valid_ff;
   logic     ri_ff, ri_in;
   logic     cj_ff, cj_in;

   logic                       has_up, row_last, has_left, col_last;
   logic [1:0]                 nr, nc;
   logic signed [POS_BITS-1:0] o, oc, r_s, c_s, h_lim, w_lim;
   logic                       emit_now, last_res, cur_done, load;
   logic [1:0]                 rsel [3];
   logic [1:0]                 csel [3];

   // Stage registers.
   logic                              a_valid_ff;
   logic [TAPS-1:0][7:0]              a_px_ff [3];
   logic [ROW_BITS-1:0]               a_row_ff;
   logic [9:0]                        a_col_ff;
   logic                              a_last_ff;
   logic                              b_valid_ff;
   logic signed [PROD_BITS-1:0]       b_prod_ff [3][TAPS];
   logic [ROW_BITS-1:0]               b_row_ff;
   logic [9:0]                        b_col_ff;
   logic                              b_last_ff;
   logic                              c_valid_ff;
   logic signed [SUM_BITS-1:0]        c_sum_ff [3];
   logic [ROW_BITS-1:0]               c_row_ff;
   logic [9:0]                        c_col_ff;
   logic                              c_last_ff;
   logic                              out_valid_ff;
   logic [RSP_DATA_BITS-1:0]          out_data_ff;
   logic                              out_last_ff;

   logic signed [SUM_BITS-1:0]        sum_in [3];
   logic [7:0]                        chan [3];

   assign pipe_en = ~out_valid_ff | rsp_tready;

   // Which output rows and columns the current pixel completes.
   always_comb begin
      has_up   = cur_ff.row != '0;
      row_last = cur_ff.row == (cur_ff.height - 16'd1);
      has_left = cur_ff.col != '0;
      col_last = WIDTH_BITS'(cur_ff.col) == (cur_ff.width - WIDTH_BITS'(1));
      nr       = 2'(has_up) + 2'(row_last);
      nc       = 2'(has_left) + 2'(col_last);
      r_s      = POS_BITS'(cur_ff.row);
      c_s      = POS_BITS'(cur_ff.col);
      h_lim    = POS_BITS'(cur_ff.height) - POS_BITS'(1);
      w_lim    = POS_BITS'(cur_ff.width) - POS_BITS'(1);
      o        = (!ri_ff && has_up) ? r_s - POS_BITS'(1) : r_s;
      oc       = (!cj_ff && has_left) ? c_s - POS_BITS'(1) : c_s;
      last_res = (2'(ri_ff) == nr - 2'd1) && (2'(cj_ff) == nc - 2'd1);
      emit_now = pipe_en && cur_valid_ff && (nr != 2'd0) && (nc != 2'd0);
      cur_done = pipe_en && cur_valid_ff
                 && ((nr == 2'd0) || (nc == 2'd0) || last_res);
      for (int d = 0; d < 3; d++) begin
         rsel[d] = slot_sel(o, 2'(d), r_s, h_lim);
         csel[d] = slot_sel(oc, 2'(d), c_s, w_lim);
      end
   end

   assign item_take = pipe_en & (~cur_valid_ff | cur_done);
   assign load      = item_take & item_valid;

   // Result index within the current pixel.
   always_comb begin
      ri_in = ri_ff;
      cj_in = cj_ff;
      if (cur_done || load) begin
         ri_in = 1'b0;
         cj_in = 1'b0;
      end else if (emit_now) begin
         if (2'(cj_ff) == nc - 2'd1) begin
            cj_in = 1'b0;
            ri_in = 1'b1;
         end else begin
            cj_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff <= item;
      end
   end

   // Stage A: window pixels picked for each kernel tap.
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int dr = 0; dr < 3; dr++) begin
            for (int dc = 0; dc < 3; dc++) begin
               for (int ch = 0; ch < 3; ch++) begin
                  a_px_ff[ch][dr*3 + dc] <=
                     cur_ff.win[4'(rsel[dr]) * 4'd3 + 4'(csel[dc])][8*ch +: 8];
               end
            end
         end
         a_row_ff  <= o[ROW_BITS-1:0];
         a_col_ff  <= oc[9:0];
         a_last_ff <= last_res;
      end
   end

   // Stage B: products of pixels and coefficients.
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int ch = 0; ch < 3; ch++) begin
            for (int k = 0; k < TAPS; k++) begin
               b_prod_ff[ch][k] <= $signed({1'b0, a_px_ff[ch][k]})
                                   * $signed(cfg.coef[k]);
            end
         end
         b_row_ff  <= a_row_ff;
         b_col_ff  <= a_col_ff;
         b_last_ff <= a_last_ff;
      end
   end

   // Stage C: channel sums.
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         sum_in[ch] = '0;
         for (int k = 0; k < TAPS; k++) begin
            sum_in[ch] = sum_in[ch] + SUM_BITS'(b_prod_ff[ch][k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int ch = 0; ch < 3; ch++) begin
            c_sum_ff[ch] <= sum_in[ch];
         end
         c_row_ff  <= b_row_ff;
         c_col_ff  <= b_col_ff;
         c_last_ff <= b_last_ff;
      end
   end

   // Floor and clamp to the pixel range.
   always_comb begin
      logic signed [SUM_BITS-1:0] sh;
      for (int ch = 0; ch < 3; ch++) begin
         sh = c_sum_ff[ch] >>> COEF_FRAC_BITS;
         if (c_sum_ff[ch] < 0) begin
            chan[ch] = 8'd0;
         end else if (sh > 255) begin
            chan[ch] = 8'd255;
         end else begin
            chan[ch] = sh[7:0];
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         out_data_ff <= {6'd0, c_col_ff, c_row_ff, chan[2], chan[1], chan[0]};
         out_last_ff <= c_last_ff;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         ri_ff        <= 1'b0;
         cj_ff        <= 1'b0;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         ri_ff <= ri_in;
         cj_ff <= cj_in;
         if (load) begin
            cur_valid_ff <= 1'b1;
         end else if (cur_done) begin
            cur_valid_ff <= 1'b0;
         end
         if (pipe_en) begin
            a_valid_ff   <= emit_now;
            b_valid_ff   <= a_valid_ff;
            c_valid_ff   <= b_valid_ff;
            out_valid_ff <= c_valid_ff;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ----- hw/rtl/rgb_convolution_3x3_mirror_border.sv -----
// 3x3 convolution of an RGB raster stream with edge-replicated borders.
// Input channel (req_): one pixel per transaction in raster order, red in the
// low byte of tdata. Result channel (rsp_): one filtered pixel per
// transaction, with its row and column; tlast marks the last result caused by
// an input pixel. An input pixel causes zero to four results.
// Configuration (csr_): APB-style, 64-bit registers at byte addresses 8*i:
// coefficient words, the last coefficient, image width and height. Writing
// width or height restarts the frame; write only while the block is idle.
// Throughput: one input pixel per clock while the receiver is ready, limited
// by the single result sequencer, which issues one result per clock unless
// the receiver stalls; a pixel at a row's last column or in the last row
// holds the input until all of its results have been issued.
// The line memory is read and written once per pixel; a same-entry access on
// consecutive pixels is served by forwarding.
// Reset clears positions, window and pipeline; the line memory is not cleared.
// When the receiver stalls, the whole result pipeline holds and the input
// channel backs up once stage one and the item register are full.
module rgb_convolution_3x3_mirror_border #(
   parameter int unsigned MAX_WIDTH      = rgbc_pkg::DEF_MAX_WIDTH,
   parameter int unsigned COEF_FRAC_BITS = rgbc_pkg::DEF_COEF_FRAC_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   // fields from bit 0: in_red, in_green, in_blue
   input  logic [rgbc_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // fields from bit 0: out_red, out_green, out_blue, out_row, out_col, zeros
   output logic [rgbc_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                               rsp_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [rgbc_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [rgbc_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [rgbc_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready
);
   import rgbc_pkg::*;

   cfg_type  cfg;
   item_type item;
   logic     item_valid;
   logic     item_take;

   rgbc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rgbc_line_buf #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_buf (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .item       (item),
      .item_valid (item_valid),
      .item_take  (item_take)
   );

   rgbc_emit #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_emit (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item       (item),
      .item_valid (item_valid),
      .item_take  (item_take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- hw/rtl/rgbc_checker.sv -----
`include "rgb_convolution_3x3_mirror_border_macros.svh"

module rgbc_checker (
   input logic                               clock,
   input logic                               reset,
   input logic [rgbc_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [rgbc_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input logic                               rsp_tlast,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic                               csr_psel,
   input logic                               csr_penable,
   input logic                               csr_pwrite,
   input logic [rgbc_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input logic [rgbc_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   input logic [rgbc_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   input logic                               csr_pready
);

   // A stalled result keeps its payload.
   `RGBC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // Out of reset the pipeline is empty and the input side is open.
   `RGBC_ASSERT_SAME(a_reset_empty, clock, 1'b0, $fell(reset), !rsp_tvalid && req_tready)

   // The padding above the column field stays zero.
   `RGBC_ASSERT_SAME(a_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[55:50] == 6'd0)

endmodule

bind rgb_convolution_3x3_mirror_border rgbc_checker u_rgbc_checker (.*);
